@@ sv/bbc_pkg.sv @@
`default_nettype none

package bbc_pkg;

  // Result codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STRAY_CLOSE = 3'd1,
    ST_MISMATCH    = 3'd2,
    ST_STRAY_OPEN  = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_t;

  // Bracket kind as held on the stack
  typedef enum logic [1:0] {
    KIND_SQUARE = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_LSQ  = 8'h5B;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_LCUR = 8'h7B;
  localparam logic [7:0] CH_RSQ  = 8'h5D;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_RCUR = 8'h7D;

  localparam int unsigned OUT_LINE_BITS = 16;

  // Packed result; status sits in the low bits
  typedef struct packed {
    logic [OUT_LINE_BITS-1:0] line_number;
    logic [7:0]               bracket_char;
    status_t                  status;
  } result_t;

  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_LSQ:  k = KIND_SQUARE;
      CH_LPAR: k = KIND_ROUND;
      CH_LCUR: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_RSQ:  k = KIND_SQUARE;
      CH_RPAR: k = KIND_ROUND;
      CH_RCUR: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Unused code (KIND_NONE) maps to square through the default branch
  function automatic logic [7:0] open_char(input kind_t k);
    logic [7:0] c;
    unique case (k)
      KIND_ROUND: c = CH_LPAR;
      KIND_CURLY: c = CH_LCUR;
      default:    c = CH_LSQ;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/bracket_balance_checker_core.sv @@
`default_nettype none

// Channel   Dir  tdata (low bit up)       tuser           tlast
// in_       in   [7:0] char_code          first_of_file   last_of_file
// out_      out  [2:0] status,            -               -
//                [10:3] bracket_char,
//                [26:11] line_number
//
// One byte per cycle while in_tready is high; each result is registered in
// the output buffer as its byte is accepted. Top and below-top stack entries
// are read each cycle from the next count: no pop stalls, top pushes forward.
// Reset is synchronous (rst_n low): count, line, halt and output valids only.
// A two-entry output buffer keeps bytes flowing while a result waits;
// in_tready drops only when both entries are full.

module bracket_balance_checker_core
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LINE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tuser,   // [0] first_of_file
  input  wire logic        in_tlast,   // last_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [2:0] status, [10:3] bracket_char,
                                       // [26:11] line_number, rest zero
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = 2 + LINE_BITS;
  localparam int unsigned SW = (LINE_BITS > OUT_LINE_BITS) ? LINE_BITS : OUT_LINE_BITS;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // stack memory: {kind, line}
  logic [EW-1:0] stack_mem [STACK_DEPTH];
  logic [EW-1:0] top_q, below_q;

  logic [CW-1:0]        count_r, count_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 halted_r, halted_nxt;

  result_t out_r, skid_r, res;
  logic    out_v_r, skid_v_r, res_v;

  logic                 acc;
  logic [CW-1:0]        cnt_eff, cnt_after;
  logic [LINE_BITS-1:0] line_eff, line_after, vline;
  logic                 halt_eff, err, push, pop;
  kind_t                ko, kc, top_kind, below_kind;
  logic [AW-1:0]        ra_top, ra_below, waddr;
  logic [EW-1:0]        wdata;

  assign in_tready = !skid_v_r;
  assign acc       = in_tvalid && in_tready;

  assign top_kind   = kind_t'(top_q[EW-1 -: 2]);
  assign below_kind = kind_t'(below_q[EW-1 -: 2]);
  assign ko         = open_kind(in_tdata);
  assign kc         = close_kind(in_tdata);

  // saturate a line value onto the 16-bit output field
  function automatic logic [OUT_LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
    logic [SW-1:0] e;
    e = SW'(v);
    if (e > SW'({OUT_LINE_BITS{1'b1}})) begin
      return {OUT_LINE_BITS{1'b1}};
    end
    return e[OUT_LINE_BITS-1:0];
  endfunction

  always_comb begin
    cnt_eff    = in_tuser ? '0 : count_r;
    line_eff   = in_tuser ? LINE_BITS'(1) : line_r;
    halt_eff   = in_tuser ? 1'b0 : halted_r;
    err        = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    res_v      = 1'b0;
    res        = '0;
    res.status = ST_OK;
    line_after = line_eff;
    cnt_after  = cnt_eff;
    vline      = '0;

    if (acc && !halt_eff) begin
      if (ko != KIND_NONE) begin
        if (cnt_eff == CW'(STACK_DEPTH)) begin
          err = 1'b1;
          res.status       = ST_OVERFLOW;
          res.bracket_char = in_tdata;
          res.line_number  = sat_line(line_eff);
        end else begin
          push      = 1'b1;
          cnt_after = cnt_eff + CW'(1);
        end
      end else if (kc != KIND_NONE) begin
        if (cnt_eff == '0) begin
          err = 1'b1;
          res.status       = ST_STRAY_CLOSE;
          res.bracket_char = in_tdata;
          res.line_number  = sat_line(line_eff);
        end else if (top_kind != kc) begin
          err = 1'b1;
          res.status       = ST_MISMATCH;
          res.bracket_char = open_char(top_kind);
          res.line_number  = sat_line(line_eff);
        end else begin
          pop       = 1'b1;
          cnt_after = cnt_eff - CW'(1);
        end
      end else if (in_tdata == CH_NL) begin
        if (line_eff != LINE_MAX) begin
          line_after = line_eff + LINE_BITS'(1);
        end
      end

      res_v = err;
      // end-of-file verdict from the stack as this byte leaves it
      if (in_tlast && !err) begin
        res_v = 1'b1;
        if (cnt_after != '0) begin
          res.status = ST_STRAY_OPEN;
          if (push) begin
            res.bracket_char = open_char(ko);
            vline            = line_eff;
          end else if (pop) begin
            res.bracket_char = open_char(below_kind);
            vline            = below_q[LINE_BITS-1:0];
          end else begin
            res.bracket_char = open_char(top_kind);
            vline            = top_q[LINE_BITS-1:0];
          end
          res.line_number = sat_line(vline);
        end
      end
    end

    count_nxt  = acc ? (err ? cnt_eff : cnt_after) : count_r;
    line_nxt   = acc ? line_after : line_r;
    halted_nxt = acc ? (halt_eff || res_v) : halted_r;
  end

  assign waddr    = cnt_eff[AW-1:0];
  assign wdata    = {ko, line_eff};
  assign ra_top   = AW'(count_nxt - CW'(1));
  assign ra_below = AW'(count_nxt - CW'(2));

  // stack memory: one write, two registered reads; a push is forwarded to the top read
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[waddr] <= wdata;
    end
    if (push && (waddr == ra_top)) begin
      top_q <= wdata;
    end else begin
      top_q <= stack_mem[ra_top];
    end
    below_q <= stack_mem[ra_below];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      line_r   <= LINE_BITS'(1);
      halted_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      line_r   <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_tready) begin
      skid_v_r <= res_v;
    end else begin
      out_v_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_r <= skid_r;
      end
    end else if (out_v_r && !out_tready) begin
      skid_r <= res;
    end else begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_r};

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without output entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_result_halts: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |=> halted_r)
    else $error("result given without halting");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_halt_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !in_tuser) |-> !push && !res_v)
    else $error("activity while halted");

endmodule

`default_nettype wire
